### hdl/udpt_pkg.sv
// ---------------------------------------------------------------------------
// UDP port table package
// Shared constants, codes and interface structs of the reference counted
// UDP destination port table.
// ---------------------------------------------------------------------------
package udpt_pkg;

	// Table geometry.
	localparam int MAX_ENTRIES = 8;
	localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
	localparam int CFG_W       = 4;
	localparam int LIM_W       = (CNT_W > CFG_W) ? CNT_W : CFG_W;
	localparam int PORT_W      = 16;
	localparam int REFS_W      = 16;
	localparam int INUSE_W     = 4;

	// Reset contents and limits.
	localparam logic [PORT_W-1:0] RESET_PORT    = 16'd4789;
	localparam logic [REFS_W-1:0] REFS_MAX      = 16'hFFFF;
	localparam logic [CFG_W-1:0]  DEFAULT_LIMIT = 4'd4;
	localparam logic [CFG_W-1:0]  CFG_RESET     = 4'd4;

	// Request codes; the unused code is served as a lookup.
	typedef enum logic [1:0] {
		REQ_LOOKUP = 2'd0,
		REQ_ADD    = 2'd1,
		REQ_DEL    = 2'd2
	} req_t;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_FULL    = 2'd1,
		ST_MISSING = 2'd2
	} status_t;

	// Outcome of the parallel compare against the table.
	typedef struct packed {
		logic              hit;
		logic [IDX_W-1:0]  hit_idx;
		logic [REFS_W-1:0] hit_refs;
		logic              free;
		logic [IDX_W-1:0]  free_idx;
	} match_t;

	// One table update.
	typedef struct packed {
		logic              en;
		logic [IDX_W-1:0]  idx;
		logic              set_valid;
		logic              clr_valid;
		logic [PORT_W-1:0] port;
		logic [REFS_W-1:0] refs;
		logic              cnt_inc;
		logic              cnt_dec;
	} wr_t;

	// One result item.
	typedef struct packed {
		status_t            status;
		logic               hit;
		logic [REFS_W-1:0]  ref_count;
		logic               hw_add_cmd;
		logic               hw_del_cmd;
		logic [INUSE_W-1:0] ports_in_use;
	} res_t;

endpackage

### hdl/udpt_table.sv
// ---------------------------------------------------------------------------
// UDP port table storage
// Holds the entries and the in-use count, compares a port against every
// valid entry at once and applies one update per cycle.
// ---------------------------------------------------------------------------
module udpt_table (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [udpt_pkg::PORT_W-1:0]  lookup_port,
	input  udpt_pkg::wr_t                wr,
	output udpt_pkg::match_t             match,
	output logic [udpt_pkg::CNT_W-1:0]   port_count
);

	logic [udpt_pkg::MAX_ENTRIES-1:0] valid_q;
	logic [udpt_pkg::PORT_W-1:0]      port_q [udpt_pkg::MAX_ENTRIES];
	logic [udpt_pkg::REFS_W-1:0]      refs_q [udpt_pkg::MAX_ENTRIES];
	logic [udpt_pkg::CNT_W-1:0]       count_q;

	// Parallel compare; scanning downward leaves the lowest index selected.
	always_comb begin
		match = '0;
		for (int i = udpt_pkg::MAX_ENTRIES - 1; i >= 0; i--) begin
			if (valid_q[i] && port_q[i] == lookup_port) begin
				match.hit     = 1'b1;
				match.hit_idx = udpt_pkg::IDX_W'(i);
			end
			if (!valid_q[i]) begin
				match.free     = 1'b1;
				match.free_idx = udpt_pkg::IDX_W'(i);
			end
		end
		match.hit_refs = refs_q[match.hit_idx];
	end

	// Entry storage; entry zero starts out holding the default port.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= udpt_pkg::MAX_ENTRIES'(1);
			for (int i = 0; i < udpt_pkg::MAX_ENTRIES; i++) begin
				port_q[i] <= '0;
				refs_q[i] <= '0;
			end
			port_q[0] <= udpt_pkg::RESET_PORT;
			refs_q[0] <= udpt_pkg::REFS_W'(1);
			count_q   <= udpt_pkg::CNT_W'(1);
		end else if (wr.en) begin
			refs_q[wr.idx] <= wr.refs;
			if (wr.set_valid) begin
				valid_q[wr.idx] <= 1'b1;
				port_q[wr.idx]  <= wr.port;
			end
			if (wr.clr_valid) begin
				valid_q[wr.idx] <= 1'b0;
			end
			if (wr.cnt_inc) begin
				count_q <= count_q + udpt_pkg::CNT_W'(1);
			end else if (wr.cnt_dec) begin
				count_q <= count_q - udpt_pkg::CNT_W'(1);
			end
		end
	end

	assign port_count = count_q;

endmodule

### hdl/udpt_ctrl.sv
// ---------------------------------------------------------------------------
// UDP port table request logic
// Decides the outcome of one request from the compare result and builds
// the table update and the result item.
// ---------------------------------------------------------------------------
module udpt_ctrl (
	input  logic [1:0]                   req_type,
	input  logic [udpt_pkg::PORT_W-1:0]  dst_port,
	input  logic [udpt_pkg::CFG_W-1:0]   max_ports,
	input  udpt_pkg::match_t             match,
	input  logic [udpt_pkg::CNT_W-1:0]   port_count,
	output udpt_pkg::wr_t                wr,
	output udpt_pkg::res_t               res
);

	logic [udpt_pkg::LIM_W-1:0] limit;
	logic [udpt_pkg::LIM_W-1:0] count_ext;
	logic [udpt_pkg::CNT_W-1:0] count_next;

	// A zero limit means the default; the limit never exceeds the table size.
	always_comb begin
		limit = (max_ports == '0) ? udpt_pkg::LIM_W'(udpt_pkg::DEFAULT_LIMIT)
		                          : udpt_pkg::LIM_W'(max_ports);
		if (limit > udpt_pkg::LIM_W'(udpt_pkg::MAX_ENTRIES)) begin
			limit = udpt_pkg::LIM_W'(udpt_pkg::MAX_ENTRIES);
		end
		count_ext = udpt_pkg::LIM_W'(port_count);
	end

	// Request decision.
	always_comb begin
		wr             = '0;
		wr.idx         = match.hit_idx;
		wr.port        = dst_port;
		res            = '0;
		res.status     = udpt_pkg::ST_OK;
		res.hit        = match.hit;
		case (req_type)
			udpt_pkg::REQ_ADD: begin
				if (match.hit) begin
					wr.en  = 1'b1;
					wr.refs = (match.hit_refs < udpt_pkg::REFS_MAX)
					        ? match.hit_refs + udpt_pkg::REFS_W'(1) : match.hit_refs;
					res.ref_count = wr.refs;
				end else if (count_ext >= limit || !match.free) begin
					res.status = udpt_pkg::ST_FULL;
				end else begin
					wr.en          = 1'b1;
					wr.idx         = match.free_idx;
					wr.set_valid   = 1'b1;
					wr.refs        = udpt_pkg::REFS_W'(1);
					wr.cnt_inc     = 1'b1;
					res.ref_count  = udpt_pkg::REFS_W'(1);
					res.hw_add_cmd = 1'b1;
				end
			end
			udpt_pkg::REQ_DEL: begin
				if (!match.hit) begin
					res.status = udpt_pkg::ST_MISSING;
				end else begin
					wr.en   = 1'b1;
					wr.refs = (match.hit_refs != '0)
					        ? match.hit_refs - udpt_pkg::REFS_W'(1) : match.hit_refs;
					res.ref_count = wr.refs;
					if (wr.refs == '0) begin
						wr.clr_valid   = 1'b1;
						wr.cnt_dec     = (port_count != '0);
						res.hw_del_cmd = 1'b1;
					end
				end
			end
			default: begin
				if (!match.hit) begin
					res.status = udpt_pkg::ST_MISSING;
				end else begin
					res.ref_count = match.hit_refs;
				end
			end
		endcase

		// Count as it stands once this request is applied.
		count_next = port_count;
		if (wr.cnt_inc) begin
			count_next = port_count + udpt_pkg::CNT_W'(1);
		end else if (wr.cnt_dec) begin
			count_next = port_count - udpt_pkg::CNT_W'(1);
		end
		res.ports_in_use = udpt_pkg::INUSE_W'(count_next);
	end

endmodule

### hdl/refcounted_udp_port_table.sv
// ---------------------------------------------------------------------------
// Reference counted UDP port table
// Top level: input register, request logic, table and result register.
// ---------------------------------------------------------------------------
// Each transfer on the slave stream is one request: tuser carries the
// request type (0 lookup, 1 add reference, 2 delete reference) and tdata
// the UDP destination port. Each request yields exactly one transfer on
// the master stream, in order.
// The request is captured in an input register; once the result register
// can take it, the compare against all entries, the decision and the table
// update happen together and the result is captured in the output register.
// The result is presented on the master stream from the result register, and
// one request is taken every cycle while the receiver does not stall; the table
// read-modify-write and the result capture happen in the same cycle.
// When the receiver stalls, the result register holds, the input register
// fills, and then s_axis_tready drops until the result is taken.
// The cfg channel writes the port limit; it is always ready.
// Reset leaves the table with port 4789 at count 1 in entry zero, all
// other entries free, and the limit at 4.
// ---------------------------------------------------------------------------
module refcounted_udp_port_table (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [3:0]  cfg_data,      // max_ports
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // dst_port[15:0]
	input  logic [1:0]  s_axis_tuser,  // req_type[1:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// hit[0], ref_count[16:1], hw_add_cmd[17], hw_del_cmd[18],
	// ports_in_use[22:19], zero[23]
	output logic [23:0] m_axis_tdata,
	output logic [1:0]  m_axis_tuser   // status[1:0]
);

	logic [udpt_pkg::CFG_W-1:0]  max_ports_q;
	logic                        in_valid_s1;
	logic [1:0]                  req_s1;
	logic [udpt_pkg::PORT_W-1:0] port_s1;
	logic                        out_valid_s2;
	udpt_pkg::res_t              res_s2;

	udpt_pkg::match_t            match;
	udpt_pkg::wr_t               wr_req;
	udpt_pkg::wr_t               wr;
	udpt_pkg::res_t              res;
	logic [udpt_pkg::CNT_W-1:0]  port_count;
	logic                        s2_ready;
	logic                        fire_s1;

	// Limit register.
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_ports_q <= udpt_pkg::CFG_RESET;
		end else if (cfg_valid) begin
			max_ports_q <= cfg_data;
		end
	end

	// Pipeline flow control.
	assign s2_ready      = !out_valid_s2 || m_axis_tready;
	assign fire_s1       = in_valid_s1 && s2_ready;
	assign s_axis_tready = !in_valid_s1 || s2_ready;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
			req_s1      <= '0;
			port_s1     <= '0;
		end else if (s_axis_tready) begin
			in_valid_s1 <= s_axis_tvalid;
			if (s_axis_tvalid) begin
				req_s1  <= s_axis_tuser;
				port_s1 <= s_axis_tdata;
			end
		end
	end

	udpt_table u_table (
		.clk         (clk),
		.arst_n      (arst_n),
		.lookup_port (port_s1),
		.wr          (wr),
		.match       (match),
		.port_count  (port_count)
	);

	udpt_ctrl u_ctrl (
		.req_type   (req_s1),
		.dst_port   (port_s1),
		.max_ports  (max_ports_q),
		.match      (match),
		.port_count (port_count),
		.wr         (wr_req),
		.res        (res)
	);

	// The table changes only when the request moves into the result register.
	always_comb begin
		wr    = wr_req;
		wr.en = wr_req.en && fire_s1;
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
			res_s2       <= '0;
		end else if (s2_ready) begin
			out_valid_s2 <= in_valid_s1;
			if (in_valid_s1) begin
				res_s2 <= res;
			end
		end
	end

	assign m_axis_tvalid = out_valid_s2;
	assign m_axis_tuser  = res_s2.status;
	assign m_axis_tdata  = {1'b0, res_s2.ports_in_use, res_s2.hw_del_cmd,
	                        res_s2.hw_add_cmd, res_s2.ref_count, res_s2.hit};

	// A result never installs and removes a port at once.
	a_add_del_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_s2 |-> !(res_s2.hw_add_cmd && res_s2.hw_del_cmd))
		else $error("result both installs and removes a port");

	// Failed requests report a zero count and issue no command.
	a_fail_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_s2 && res_s2.status != udpt_pkg::ST_OK) |->
		(res_s2.ref_count == '0 && !res_s2.hw_add_cmd && !res_s2.hw_del_cmd))
		else $error("failed request carries a count or a command");

	// The in-use count never exceeds the table size.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		port_count <= udpt_pkg::CNT_W'(udpt_pkg::MAX_ENTRIES))
		else $error("in-use count beyond table size");

	// An install raises the in-use count by one in the next cycle.
	a_install_count: assert property (@(posedge clk) disable iff (!arst_n)
		(wr.en && wr.cnt_inc) |=> port_count == $past(port_count) + udpt_pkg::CNT_W'(1))
		else $error("install did not raise the in-use count");

endmodule
